[hw/rtl/scwf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scwf_pkg: shared types and constants for the SPI CRC-16 write framer
// Word layouts on both channels, the queued job format, and the CRC step.
// ----------------------------------------------------------------------------
package scwf_pkg;

  localparam logic [15:0] CrcPoly = 16'h8005;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  // Input word kinds
  localparam logic CmdHeader = 1'b0;
  localparam logic CmdData   = 1'b1;

  // Byte counts per job
  localparam logic [2:0] HdrBytes  = 3'd3;
  localparam logic [2:0] DataBytes = 3'd1;
  localparam logic [2:0] CrcBytes  = 3'd2;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  instruction;
    logic [11:0] address;
    logic [7:0]  frame_length;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_word_t;

  // One classified job: a header (three bytes) or a data byte, with a flag
  // to append the CRC after it.
  typedef struct packed {
    logic       hdr;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
  } job_t;

  // MSB-first CRC update over one byte
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      if (b[i] ^ c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/scwf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scwf_front: input classifier
// Accepts words, tracks the open frame and pushes jobs into the queue.
// ----------------------------------------------------------------------------
module scwf_front import scwf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_word_i,
  input  logic     q_full_i,
  output logic     push_o,
  output job_t     job_o
);

  logic       open_q, open_d;
  logic [7:0] left_q, left_d;
  logic [7:0] left_m1;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign left_m1    = left_q - 8'd1;

  always_comb begin
    open_d = open_q;
    left_d = left_q;
    push_o = 1'b0;
    job_o  = '0;
    if (accept) begin
      if (in_word_i.cmd == CmdHeader) begin
        // Restart the frame; an empty frame closes at once
        push_o   = 1'b1;
        job_o.hdr  = 1'b1;
        job_o.b0   = {in_word_i.instruction, in_word_i.address[11:8]};
        job_o.b1   = in_word_i.address[7:0];
        job_o.b2   = in_word_i.frame_length;
        job_o.last = (in_word_i.frame_length == 8'd0);
        open_d   = (in_word_i.frame_length != 8'd0);
        left_d   = in_word_i.frame_length;
      end else if (open_q) begin
        push_o   = 1'b1;
        job_o.hdr  = 1'b0;
        job_o.b0   = in_word_i.data_byte;
        job_o.last = (left_m1 == 8'd0);
        open_d   = (left_m1 != 8'd0);
        left_d   = left_m1;
      end
      // Drop data words outside a frame
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= 8'd0;
    end else begin
      open_q <= open_d;
      left_q <= left_d;
    end
  end

endmodule

[hw/rtl/scwf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scwf_queue: job queue
// Small FIFO that decouples the classifier from the byte sequencer.
// ----------------------------------------------------------------------------
module scwf_queue import scwf_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic empty_o,
  output logic full_o,
  output job_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FullCnt);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[hw/rtl/scwf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scwf_back: byte sequencer
// Emits the bytes of each job one per cycle unless stalled, and keeps the running CRC.
// ----------------------------------------------------------------------------
module scwf_back import scwf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic [2:0]  phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q;
  out_word_t   out_word_q, out_word_d;
  logic [2:0]  nbytes, total;
  logic [7:0]  pay;
  logic        adv, fire, last_step;

  assign adv       = !out_valid_q || !out_stall_i;
  assign fire      = adv && !q_empty_i;
  assign nbytes    = job_i.hdr ? HdrBytes : DataBytes;
  assign total     = nbytes + (job_i.last ? CrcBytes : 3'd0);
  assign last_step = (phase_q == total - 3'd1);
  assign pop_o     = fire && last_step;

  always_comb begin
    pay        = (phase_q == 3'd0) ? job_i.b0 : (phase_q == 3'd1) ? job_i.b1 : job_i.b2;
    crc_d      = crc_q;
    out_word_d = '0;
    if (phase_q < nbytes) begin
      out_word_d.out_byte = pay;
      crc_d = crc_byte((phase_q == 3'd0 && job_i.hdr) ? CrcInit : crc_q, pay);
    end else if (phase_q == nbytes) begin
      out_word_d.out_byte = crc_q[15:8];
    end else begin
      out_word_d.out_byte  = crc_q[7:0];
      out_word_d.frame_end = 1'b1;
    end
    phase_d = phase_q;
    if (fire) begin
      phase_d = last_step ? 3'd0 : phase_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 3'd0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (fire) begin
        crc_q       <= crc_d;
        out_valid_q <= 1'b1;
      end else if (adv) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[hw/rtl/spi_crc16_write_framer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_crc16_write_framer: CRC-protected SPI write frame builder
// Turns header and data words into a byte stream closed by a CRC-16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i): a header word
//   (cmd = 0) opens a frame and yields the two command bytes and the length
//   byte; each data word (cmd = 1) yields its byte. After the last data
//   byte, or right after the header when the length is zero, the CRC high
//   and low bytes follow, the low byte marked with frame_end. Data words
//   outside a frame are dropped; a header mid-frame restarts the frame.
//   Output channel (out_valid_o / out_stall_i / out_word_o): one byte a word.
//   The first byte of a word passes through the job queue and the output register.
//   Throughput: the sequencer emits one byte per cycle unless stalled, so
//   a header yields 3 or 5 bytes and a data word 1 or 3; the input takes
//   one word per cycle while the job queue (QueueDepth entries) has room.
//   When the receiver stalls, the output word holds, the queue fills and
//   in_stall_o rises once it is full.
//   Reset empties the queue, clears the output valid flag and the open frame.
// ----------------------------------------------------------------------------
module spi_crc16_write_framer import scwf_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic push, pop, q_empty, q_full;
  job_t push_job, head_job;

  // Classify words and track the frame
  scwf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // Decouple the two sides
  scwf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .empty_o (q_empty),
    .full_o  (q_full),
    .head_o  (head_job)
  );

  // Emit bytes and append the CRC
  scwf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
